// ===== sv/pbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbd_pkg: shared types and constants
// Slot geometry, beat layout and the cell-chain link types of the
// priority buffer with displacement.
// ----------------------------------------------------------------------------
package pbd_pkg;

    localparam int SLOTS       = 8;
    localparam int SOURCE_BITS = 4;
    localparam int TAG_BITS    = 16;
    localparam int COUNT_BITS  = 4;                     // occupancy field width
    localparam int CNT_BITS    = $clog2(SLOTS + 1);     // internal occupancy counter

    // beat layout
    localparam int S_DATA_BITS = ((SOURCE_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((SOURCE_BITS + TAG_BITS + COUNT_BITS + 7) / 8) * 8;
    localparam int M_USER_BITS = 3;

    // request kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef struct packed {
        logic                   full;
        logic [SOURCE_BITS-1:0] source;
        logic [TAG_BITS-1:0]    tag;
    } slot_t;

    // running minimum handed from front to back
    typedef struct packed {
        logic                   found;
        logic [SOURCE_BITS-1:0] source;
    } min_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic                   ins;
        logic                   rem;
        logic [SOURCE_BITS-1:0] best_src;
        logic [SOURCE_BITS-1:0] new_src;
        logic [TAG_BITS-1:0]    new_tag;
    } cell_ctl_t;

endpackage

// ===== sv/priority_buffer_with_displacement.sv =====
// ----------------------------------------------------------------------------
// priority_buffer_with_displacement: packet buffer, lowest source served first
// A chain of SLOTS cells keeps packets packed in arrival order; inserts fill
// the first free cell or displace the tail, removes serve the lowest source.
// ----------------------------------------------------------------------------
// Sequencing: s_tready is high only when idle, so one item is finished before the
//   next input beat is taken; the sequencer runs a search step (min-source chain
//   over all cells) and then an apply step (selection chain, shift and output
//   register) per item. The apply step waits while the result beat is stalled.
// Reset: synchronous, active low; clears occupancy, the sequencer and the result
//   valid flag. Slot contents are not cleared, only marked empty.
module priority_buffer_with_displacement (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pbd_pkg::S_DATA_BITS-1:0] s_tdata,  // [3:0] source, [19:4] tag, rest zero
    input  logic                            s_tuser,  // [0] kind: 0 insert, 1 remove
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pbd_pkg::M_DATA_BITS-1:0] m_tdata,  // [3:0] packet_source,
                                                      // [19:4] packet_tag,
                                                      // [23:20] occupied_count
    output logic [pbd_pkg::M_USER_BITS-1:0] m_tuser   // [0] packet_valid,
                                                      // [1] packet_dropped,
                                                      // [2] empty_error
);
    import pbd_pkg::*;

    // sequencer codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_APPLY  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic                   kind_reg;
    logic [SOURCE_BITS-1:0] src_reg;
    logic [TAG_BITS-1:0]    tag_reg;
    min_t                   best_reg;
    logic [CNT_BITS-1:0]    count_reg, count_next;

    // output register
    logic                   m_valid_reg;
    logic                   valid_reg, valid_next;
    logic                   dropped_reg, dropped_next;
    logic                   err_reg, err_next;
    logic [SOURCE_BITS-1:0] osrc_reg, osrc_next;
    logic [TAG_BITS-1:0]    otag_reg, otag_next;

    logic                   s_fire;
    logic                   out_free;
    logic                   apply;
    cell_ctl_t              ctl;

    // cell chain links
    slot_t cell_slot [SLOTS];
    slot_t prev_in   [SLOTS];
    slot_t next_in   [SLOTS];
    min_t  min_chain [SLOTS+1];
    logic  seen_chain[SLOTS+1];
    slot_t pick_chain[SLOTS+1];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign apply    = (state_reg == ST_APPLY) && out_free;

    // chain ends: the front sees a full neighbor, the tail pulls in an empty slot
    assign min_chain[0]  = '0;
    assign seen_chain[0] = 1'b0;
    assign pick_chain[0] = '0;

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        if (i == 0) begin : g_front
            assign prev_in[i] = '{full: 1'b1, source: '0, tag: '0};
        end else begin : g_mid
            assign prev_in[i] = cell_slot[i-1];
        end
        if (i == SLOTS - 1) begin : g_tail
            assign next_in[i] = '0;
        end else begin : g_body
            assign next_in[i] = cell_slot[i+1];
        end

        pbd_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .is_tail   (i == SLOTS - 1),
            .ctl       (ctl),
            .prev_slot (prev_in[i]),
            .next_slot (next_in[i]),
            .min_in    (min_chain[i]),
            .min_out   (min_chain[i+1]),
            .seen_in   (seen_chain[i]),
            .seen_out  (seen_chain[i+1]),
            .pick_in   (pick_chain[i]),
            .pick_out  (pick_chain[i+1]),
            .slot      (cell_slot[i])
        );
    end

    // apply step: decide the command and the result beat
    always_comb begin
        ctl          = '0;
        ctl.best_src = best_reg.source;
        ctl.new_src  = src_reg;
        ctl.new_tag  = tag_reg;
        count_next   = count_reg;
        valid_next   = 1'b0;
        dropped_next = 1'b0;
        err_next     = 1'b0;
        osrc_next    = '0;
        otag_next    = '0;
        if (kind_reg == KIND_INSERT) begin
            ctl.ins = apply;
            if (cell_slot[SLOTS-1].full) begin
                // tail packet is displaced
                valid_next   = 1'b1;
                dropped_next = 1'b1;
                osrc_next    = cell_slot[SLOTS-1].source;
                otag_next    = cell_slot[SLOTS-1].tag;
            end else begin
                count_next = count_reg + CNT_BITS'(1);
            end
        end else if (best_reg.found) begin
            ctl.rem    = apply;
            valid_next = 1'b1;
            osrc_next  = pick_chain[SLOTS].source;
            otag_next  = pick_chain[SLOTS].tag;
            count_next = count_reg - CNT_BITS'(1);
        end else begin
            err_next = 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_fire) state_next = ST_SEARCH;
            ST_SEARCH: state_next = ST_APPLY;
            ST_APPLY:  if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (apply) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, search result and result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg <= s_tuser;
            src_reg  <= s_tdata[SOURCE_BITS-1:0];
            tag_reg  <= s_tdata[SOURCE_BITS +: TAG_BITS];
        end
        if (state_reg == ST_SEARCH) begin
            best_reg <= min_chain[SLOTS];
        end
        if (apply) begin
            valid_reg   <= valid_next;
            dropped_reg <= dropped_next;
            err_reg     <= err_next;
            osrc_reg    <= osrc_next;
            otag_reg    <= otag_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_BITS'({COUNT_BITS'(count_reg), otag_reg, osrc_reg});
    assign m_tuser  = {err_reg, dropped_reg, valid_reg};

endmodule

// ===== sv/pbd_cell.sv =====
// ----------------------------------------------------------------------------
// pbd_cell: one buffer slot
// Holds one packet, joins the min-source and selection chains, and shifts
// toward the front when it or a packet ahead of it is served.
// ----------------------------------------------------------------------------
module pbd_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              is_tail,
    input  pbd_pkg::cell_ctl_t ctl,
    input  pbd_pkg::slot_t    prev_slot,
    input  pbd_pkg::slot_t    next_slot,
    input  pbd_pkg::min_t     min_in,
    output pbd_pkg::min_t     min_out,
    input  logic              seen_in,
    output logic              seen_out,
    input  pbd_pkg::slot_t    pick_in,
    output pbd_pkg::slot_t    pick_out,
    output pbd_pkg::slot_t    slot
);
    import pbd_pkg::*;

    logic                   full_reg;
    logic [SOURCE_BITS-1:0] source_reg;
    logic [TAG_BITS-1:0]    tag_reg;
    logic                   selected;
    logic                   take_new;
    logic                   shift;

    assign slot = '{full: full_reg, source: source_reg, tag: tag_reg};

    // strict less keeps the frontmost packet on ties
    always_comb begin
        min_out.found  = min_in.found | full_reg;
        min_out.source = min_in.source;
        if (full_reg && (!min_in.found || source_reg < min_in.source)) begin
            min_out.source = source_reg;
        end
    end

    assign selected = full_reg && (source_reg == ctl.best_src) && !seen_in;
    assign seen_out = seen_in | selected;
    assign pick_out = selected ? slot : pick_in;
    assign shift    = ctl.rem && seen_out;

    // first free slot, or the tail slot when it gets displaced
    assign take_new = ctl.ins && ((!full_reg && prev_slot.full) || (is_tail && full_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (take_new) begin
            full_reg <= 1'b1;
        end else if (shift) begin
            full_reg <= next_slot.full;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_new) begin
            source_reg <= ctl.new_src;
            tag_reg    <= ctl.new_tag;
        end else if (shift) begin
            source_reg <= next_slot.source;
            tag_reg    <= next_slot.tag;
        end
    end

endmodule

// ===== sv/pbd_checker.sv =====
// ----------------------------------------------------------------------------
// pbd_checker: port-level checks
// Watches the result channel of the buffer; attached by bind.
// ----------------------------------------------------------------------------
module pbd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pbd_pkg::M_DATA_BITS-1:0] m_tdata,
    input logic [pbd_pkg::M_USER_BITS-1:0] m_tuser
);
    import pbd_pkg::*;

    localparam int CNT_LSB = SOURCE_BITS + TAG_BITS;

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // an empty remove never also delivers a packet and reports zero occupancy
    a_err_no_pkt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> !m_tuser[0] && !m_tuser[1]
            && m_tdata[CNT_LSB +: COUNT_BITS] == COUNT_BITS'(0))
        else $error("empty error with packet or nonzero occupancy");

    // displacement only happens on a full buffer, and it is a leaving packet
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0]
            && m_tdata[CNT_LSB +: COUNT_BITS] == COUNT_BITS'(SLOTS))
        else $error("drop reported without a full buffer");

    // occupancy never exceeds the slot count
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[CNT_LSB +: COUNT_BITS] <= COUNT_BITS'(SLOTS))
        else $error("occupancy out of range");

endmodule

bind priority_buffer_with_displacement pbd_checker u_pbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== sim/priority_buffer_with_displacement_tb.sv =====
// ----------------------------------------------------------------------------
// priority_buffer_with_displacement_tb: self-checking stream testbench
// Drives insert and remove beats into the packet buffer and checks every
// result beat against a cycle-free model of the slot array kept in the bench.
// A short table covers reset, the field extremes, tail displacement, ties and
// removes on an empty buffer. Random traffic follows, under several idle and
// stall mixes, with one long output hold-off and a full drain midway.
// ----------------------------------------------------------------------------
module priority_buffer_with_displacement_tb;

    import pbd_pkg::*;

    localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES   = 80;    // long output hold-off
    localparam int DRAIN_SLACK   = 8;     // slack after the last result has drained
    localparam int NUM_DIRECTED  = 24;

    // one result beat, unpacked from m_tdata / m_tuser
    typedef struct packed {
        logic                   pkt_valid;
        logic                   pkt_dropped;
        logic [SOURCE_BITS-1:0] pkt_source;
        logic [TAG_BITS-1:0]    pkt_tag;
        logic                   empty_err;
        logic [COUNT_BITS-1:0]  occupancy;
    } outcome_t;

    // directed stimulus row; 'typed' rows carry their own expected result
    typedef struct packed {
        logic                   kind;
        logic [SOURCE_BITS-1:0] source;
        logic [TAG_BITS-1:0]    tag;
        logic                   typed;
        outcome_t               want;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // remove right after reset: empty error, nothing leaves
        '{KIND_REMOVE, 4'h0, 16'h0000, 1'b1, '{1'b0, 1'b0, 4'h0, 16'h0000, 1'b1, 4'd0}},
        // field extremes on insert
        '{KIND_INSERT, 4'hf, 16'hffff, 1'b1, '{1'b0, 1'b0, 4'h0, 16'h0000, 1'b0, 4'd1}},
        '{KIND_INSERT, 4'h0, 16'h0000, 1'b1, '{1'b0, 1'b0, 4'h0, 16'h0000, 1'b0, 4'd2}},
        '{KIND_INSERT, 4'h7, 16'ha5a5, 1'b0, '0},
        '{KIND_INSERT, 4'h0, 16'h1234, 1'b0, '0},
        '{KIND_INSERT, 4'h8, 16'h5a5a, 1'b0, '0},
        '{KIND_INSERT, 4'hf, 16'h0001, 1'b0, '0},
        '{KIND_INSERT, 4'h3, 16'hfffe, 1'b0, '0},
        // last slot filled
        '{KIND_INSERT, 4'h9, 16'h8000, 1'b1, '{1'b0, 1'b0, 4'h0, 16'h0000, 1'b0, 4'd8}},
        // full buffer: the tail packet is displaced twice in a row
        '{KIND_INSERT, 4'h2, 16'h4321, 1'b1, '{1'b1, 1'b1, 4'h9, 16'h8000, 1'b0, 4'd8}},
        '{KIND_INSERT, 4'h1, 16'hcafe, 1'b1, '{1'b1, 1'b1, 4'h2, 16'h4321, 1'b0, 4'd8}},
        // two packets share source 0: the front one goes first
        '{KIND_REMOVE, 4'h5, 16'h1111, 1'b1, '{1'b1, 1'b0, 4'h0, 16'h0000, 1'b0, 4'd7}},
        '{KIND_REMOVE, 4'h0, 16'h0000, 1'b0, '0},
        '{KIND_REMOVE, 4'ha, 16'h2222, 1'b0, '0},
        '{KIND_REMOVE, 4'h0, 16'h0000, 1'b0, '0},
        '{KIND_REMOVE, 4'h0, 16'h0000, 1'b0, '0},
        '{KIND_REMOVE, 4'h0, 16'h0000, 1'b0, '0},
        '{KIND_REMOVE, 4'h0, 16'h0000, 1'b0, '0},
        '{KIND_REMOVE, 4'h0, 16'h0000, 1'b0, '0},
        // drained: remove with junk fields is an empty error again
        '{KIND_REMOVE, 4'hf, 16'hffff, 1'b1, '{1'b0, 1'b0, 4'h0, 16'h0000, 1'b1, 4'd0}},
        '{KIND_INSERT, 4'h5, 16'h0f0f, 1'b0, '0},
        '{KIND_INSERT, 4'h5, 16'hf0f0, 1'b0, '0},
        '{KIND_REMOVE, 4'h0, 16'h0000, 1'b1, '{1'b1, 1'b0, 4'h5, 16'h0f0f, 1'b0, 4'd1}},
        '{KIND_REMOVE, 4'h0, 16'h0000, 1'b1, '{1'b1, 1'b0, 4'h5, 16'hf0f0, 1'b0, 4'd0}}
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_BITS-1:0] s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_BITS-1:0] m_tdata;
    logic [M_USER_BITS-1:0] m_tuser;

    // bench copy of the slot array
    logic                   model_full   [SLOTS];
    logic [SOURCE_BITS-1:0] model_source [SLOTS];
    logic [TAG_BITS-1:0]    model_tag    [SLOTS];

    outcome_t pending_q[$];     // expected result beats, oldest first

    int sender_idle_pct;        // chance of a gap before each request beat
    int recv_stall_pct;         // chance of m_tready low in a cycle
    bit hold_start;             // asks the receiver for one long hold-off
    int error_count;
    int beats_in;
    int beats_out;
    int inserts_sent;
    int removes_sent;
    int drops_expected;
    int empty_expected;
    int peak_fill;

    priority_buffer_with_displacement u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Slot model: one call per accepted request beat, returns its result
    // ------------------------------------------------------------------
    function automatic outcome_t serve_or_store(logic kind,
                                                logic [SOURCE_BITS-1:0] src,
                                                logic [TAG_BITS-1:0] tg);
        outcome_t res;
        int       best;
        int       fill;
        bit       placed;
        res    = '0;
        best   = -1;
        fill   = 0;
        placed = 1'b0;
        if (kind == KIND_INSERT) begin
            if (model_full[SLOTS-1]) begin
                // tail is taken: its packet leaves, the new one takes its place
                res.pkt_valid   = 1'b1;
                res.pkt_dropped = 1'b1;
                res.pkt_source  = model_source[SLOTS-1];
                res.pkt_tag     = model_tag[SLOTS-1];
                model_source[SLOTS-1] = src;
                model_tag[SLOTS-1]    = tg;
            end else begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!placed && !model_full[i]) begin
                        model_full[i]   = 1'b1;
                        model_source[i] = src;
                        model_tag[i]    = tg;
                        placed          = 1'b1;
                    end
                end
            end
        end else begin
            // strict less-than keeps the frontmost packet on a tie
            for (int i = 0; i < SLOTS; i++) begin
                if (model_full[i] && (best < 0 || model_source[i] < model_source[best]))
                    best = i;
            end
            if (best < 0) begin
                res.empty_err = 1'b1;
            end else begin
                res.pkt_valid  = 1'b1;
                res.pkt_source = model_source[best];
                res.pkt_tag    = model_tag[best];
                for (int i = best; i + 1 < SLOTS; i++) begin
                    model_full[i]   = model_full[i+1];
                    model_source[i] = model_source[i+1];
                    model_tag[i]    = model_tag[i+1];
                end
                model_full[SLOTS-1] = 1'b0;
            end
        end
        for (int i = 0; i < SLOTS; i++)
            if (model_full[i])
                fill++;
        res.occupancy = fill[COUNT_BITS-1:0];
        if (fill > peak_fill)
            peak_fill = fill;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("beat %0d %s = 0x%0h, want 0x%0h",
                                      beats_out, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Request side. Called just after a rising edge (or at start); holds
    // s_tvalid high across back-to-back beats, one assignment per edge.
    // ------------------------------------------------------------------
    task automatic send_request(input logic kind,
                                input logic [SOURCE_BITS-1:0] src,
                                input logic [TAG_BITS-1:0] tg,
                                input logic use_typed,
                                input outcome_t typed_res);
        outcome_t res;
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_DATA_BITS'($urandom);     // junk while idle
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_DATA_BITS-SOURCE_BITS-TAG_BITS){1'b0}}, tg, src};
        do @(posedge aclk); while (!s_tready);
        res = serve_or_store(kind, src, tg);
        pending_q.insert(pending_q.size(), use_typed ? typed_res : res);
        beats_in++;
        if (kind == KIND_INSERT)
            inserts_sent++;
        else
            removes_sent++;
        if (res.pkt_dropped)
            drops_expected++;
        if (res.empty_err)
            empty_expected++;
    endtask

    task automatic stop_requests();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    // random traffic; sources lean toward a few low values to get ties
    task automatic send_random(input int n, input int insert_pct);
        logic                   kind;
        logic [SOURCE_BITS-1:0] src;
        for (int i = 0; i < n; i++) begin
            kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
            src  = $urandom_range(1) ? SOURCE_BITS'($urandom_range(3))
                                     : SOURCE_BITS'($urandom_range(15));
            send_request(kind, src, TAG_BITS'($urandom), 1'b0, '0);
        end
    endtask

    // sender stops until every expected result has come back
    task automatic wait_drained();
        while (pending_q.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Result side: m_tready is changed at the falling edge only
    // ------------------------------------------------------------------
    initial begin : result_ready
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (pending_q.size() == 0) begin
                report_mismatch($sformatf("beat %0d arrived with nothing expected",
                                          beats_out));
            end else begin
                want = pending_q.pop_front();
                check_field("packet_valid",   m_tuser[0],       want.pkt_valid);
                check_field("packet_dropped", m_tuser[1],       want.pkt_dropped);
                check_field("empty_error",    m_tuser[2],       want.empty_err);
                check_field("packet_source",  m_tdata[3:0],     want.pkt_source);
                check_field("packet_tag",     m_tdata[19:4],    want.pkt_tag);
                check_field("occupied_count", m_tdata[23:20],   want.occupancy);
            end
        end
    end

    // watchdog: too long without a beat on either side ends the run
    always @(posedge aclk) begin : quiet_watch
        int quiet;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("[%0t] no beat for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = KIND_INSERT;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_start      = 1'b0;
        error_count     = 0;
        beats_in        = 0;
        beats_out       = 0;
        inserts_sent    = 0;
        removes_sent    = 0;
        drops_expected  = 0;
        empty_expected  = 0;
        peak_fill       = 0;
        for (int i = 0; i < SLOTS; i++) begin
            model_full[i]   = 1'b0;
            model_source[i] = '0;
            model_tag[i]    = '0;
        end

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed table, no idling
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].source,
                         DIRECTED_ROWS[i].tag, DIRECTED_ROWS[i].typed,
                         DIRECTED_ROWS[i].want);

        // full speed on both sides
        send_random(80, 60);

        // sender mostly idle
        sender_idle_pct = 75;
        send_random(80, 50);

        // sender pauses until the buffer has answered everything
        stop_requests();
        wait_drained();

        // receiver mostly stalled; insert-heavy to keep the tail displacing
        sender_idle_pct = 0;
        recv_stall_pct  = 75;
        send_random(80, 70);

        // long hold-off on the result side while requests keep coming
        recv_stall_pct = 0;
        hold_start     = 1'b1;
        send_random(14, 60);

        // light idling on both sides
        sender_idle_pct = 20;
        recv_stall_pct  = 20;
        send_random(80, 45);

        // a final stretch with no idling
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_random(50, 55);

        stop_requests();
        wait_drained();
        repeat (DRAIN_SLACK) @(posedge aclk);

        $display("Covered %0d request beats (%0d inserts, %0d removes), %0d results checked.",
                 beats_in, inserts_sent, removes_sent, beats_out);
        $display("Tail displacements: %0d, empty removes: %0d, peak occupancy: %0d of %0d.",
                 drops_expected, empty_expected, peak_fill, SLOTS);
        if (error_count == 0 && pending_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     error_count, pending_q.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
